[design/md5_byte_stream_hasher_unit_defines.svh]
// Assertion helpers used by the checker file of the hasher.
`ifndef MD5_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define MD5_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MD5BSH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MD5BSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/md5bsh_pkg.sv]
package md5bsh_pkg;

   // Request action codes.
   localparam logic [1:0] ACT_ABSORB        = 2'd0;
   localparam logic [1:0] ACT_ABSORB_DIGEST = 2'd1;
   localparam logic [1:0] ACT_DIGEST        = 2'd2;
   localparam logic [1:0] ACT_RESTART       = 2'd3;

   // The four MD5 working words.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5bsh_words_type;

   localparam md5bsh_words_type CHAIN_INIT = '{
      a: 32'h67452301, b: 32'hefcdab89, c: 32'h98badcfe, d: 32'h10325476};

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

   // Rotate amounts, indexed by stage and the low two bits of the round.
   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

   // Message word used by a given round.
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] lo;
      logic [3:0] idx;
      lo = rnd[3:0];
      unique case (rnd[5:4])
         2'd0: idx = lo;
         2'd1: idx = 4'(4'd5 * lo + 4'd1);
         2'd2: idx = 4'(4'd3 * lo + 4'd5);
         2'd3: idx = 4'(4'd7 * lo);
      endcase
      return idx;
   endfunction

   // Word-wise modulo 2^32 sum of two word sets.
   function automatic md5bsh_words_type words_add(input md5bsh_words_type x,
                                                  input md5bsh_words_type y);
      md5bsh_words_type s;
      s.a = x.a + y.a;
      s.b = x.b + y.b;
      s.c = x.c + y.c;
      s.d = x.d + y.d;
      return s;
   endfunction

endpackage

[design/md5bsh_round.sv]
module md5bsh_round
   import md5bsh_pkg::*;
(
   input  logic [5:0]       rnd_idx,
   input  md5bsh_words_type cur_words,
   input  logic [31:0]      msg_word,
   output md5bsh_words_type nxt_words
);

   logic [31:0] mix;
   logic [31:0] sum;
   logic [4:0]  shamt;
   logic [31:0] rotated;

   // Stage-dependent boolean mixing function.
   always_comb begin
      unique case (rnd_idx[5:4])
         2'd0: mix = (cur_words.b & cur_words.c) | (~cur_words.b & cur_words.d);
         2'd1: mix = (cur_words.b & cur_words.d) | (cur_words.c & ~cur_words.d);
         2'd2: mix = cur_words.b ^ cur_words.c ^ cur_words.d;
         2'd3: mix = cur_words.c ^ (cur_words.b | ~cur_words.d);
      endcase
   end

   // One MD5 step: add, rotate left, add, then rotate the word set.
   assign sum     = cur_words.a + mix + msg_word + ROUND_CONST[rnd_idx];
   assign shamt   = ROT_AMOUNT[{rnd_idx[5:4], rnd_idx[1:0]}];
   assign rotated = (sum << shamt) | (sum >> (6'd32 - {1'b0, shamt}));

   assign nxt_words.a = cur_words.d;
   assign nxt_words.b = cur_words.b + rotated;
   assign nxt_words.c = cur_words.b;
   assign nxt_words.d = cur_words.c;

endmodule

[design/md5_byte_stream_hasher_unit.sv]
// A byte that completes a 64-byte block keeps the unit busy while the block is
// compressed (load, 64 rounds on the shared round unit, final add). A digest
// runs the same steps on a copy, twice if the padding spills into a second block,
// after compressing any block the absorbed byte fills. The round unit sets the rate.
// The four words then leave at one beat per cycle while rsp_ready is high.
// Reset is synchronous: chaining words return to the MD5 constants, count to zero.
module md5_byte_stream_hasher_unit
   import md5bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN_START,
      ST_LOAD,
      ST_RUN,
      ST_ADD,
      ST_OUT
   } state_type;

   state_type        state_ff, state_in;
   md5bsh_words_type chain_ff, chain_in;
   md5bsh_words_type digest_ff, digest_in;
   md5bsh_words_type work_ff, work_in;
   md5bsh_words_type round_out;
   logic [63:0]      count_ff, count_in;
   logic [5:0]       rnd_ff, rnd_in;
   logic [6:0]       fill_ff, fill_in;
   logic             to_chain_ff, to_chain_in;
   logic             fin_pend_ff, fin_pend_in;
   logic             second_ff, second_in;
   logic             zero_blk_ff, zero_blk_in;
   logic             len_en_ff, len_en_in;
   logic [1:0]       idx_ff, idx_in;

   // Block buffer: sixteen little-endian words, written a byte lane at a time.
   logic [31:0]      buf_mem [16];
   logic [31:0]      rd_data_ff;
   logic [3:0]       rd_word_ff;
   logic [3:0]       rd_addr;
   logic             wr_en;
   logic [31:0]      msg_word;

   // Message word of the block under compression, with padding and length
   // laid over the buffer contents.
   function automatic logic [31:0] pad_word(input logic [31:0] raw,
                                            input logic [3:0]  widx,
                                            input logic [6:0]  fill,
                                            input logic        zero_blk,
                                            input logic        len_en,
                                            input logic [63:0] count);
      logic [31:0] w;
      logic [6:0]  pos;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         pos = {1'b0, widx, 2'(j)};
         if (zero_blk) begin
            w[8*j +: 8] = 8'h00;
         end else if (pos < fill) begin
            w[8*j +: 8] = raw[8*j +: 8];
         end else if (pos == fill) begin
            w[8*j +: 8] = 8'h80;
         end else begin
            w[8*j +: 8] = 8'h00;
         end
      end
      if (len_en && widx == 4'd14) begin
         w = count[31:0];
      end else if (len_en && widx == 4'd15) begin
         w = count[63:32];
      end
      return w;
   endfunction

   assign rd_addr  = (state_ff == ST_LOAD) ? 4'd0 : msg_index(rnd_ff + 6'd1);
   assign msg_word = pad_word(rd_data_ff, rd_word_ff, fill_ff, zero_blk_ff, len_en_ff,
                              count_ff);

   // Buffer write on absorb, registered read of the next round's word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[count_ff[8:5]][8*count_ff[4:3] +: 8] <= req_data_byte;
      end
      rd_data_ff <= buf_mem[rd_addr];
      rd_word_ff <= rd_addr;
   end

   md5bsh_round u_round (
      .rnd_idx   (rnd_ff),
      .cur_words (work_ff),
      .msg_word  (msg_word),
      .nxt_words (round_out)
   );

   // Sequencer next-state logic.
   always_comb begin
      state_in    = state_ff;
      chain_in    = chain_ff;
      digest_in   = digest_ff;
      work_in     = work_ff;
      count_in    = count_ff;
      rnd_in      = rnd_ff;
      fill_in     = fill_ff;
      to_chain_in = to_chain_ff;
      fin_pend_in = fin_pend_ff;
      second_in   = second_ff;
      zero_blk_in = zero_blk_ff;
      len_en_in   = len_en_ff;
      idx_in      = idx_ff;
      wr_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  ACT_RESTART: begin
                     chain_in = CHAIN_INIT;
                     count_in = '0;
                  end
                  ACT_DIGEST: begin
                     state_in = ST_FIN_START;
                  end
                  ACT_ABSORB, ACT_ABSORB_DIGEST: begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 64'd8;
                     if (count_ff[8:3] == 6'd63) begin
                        // Full block: compress into the chaining words first.
                        state_in    = ST_LOAD;
                        to_chain_in = 1'b1;
                        fill_in     = 7'd64;
                        zero_blk_in = 1'b0;
                        len_en_in   = 1'b0;
                        fin_pend_in = (req_action == ACT_ABSORB_DIGEST);
                     end else if (req_action == ACT_ABSORB_DIGEST) begin
                        state_in = ST_FIN_START;
                     end
                  end
               endcase
            end
         end
         ST_FIN_START: begin
            // Digest works on a copy; the running state stays untouched.
            state_in    = ST_LOAD;
            digest_in   = chain_ff;
            fill_in     = {1'b0, count_ff[8:3]};
            to_chain_in = 1'b0;
            zero_blk_in = 1'b0;
            len_en_in   = (count_ff[8:3] < 6'd56);
            second_in   = !(count_ff[8:3] < 6'd56);
         end
         ST_LOAD: begin
            state_in = ST_RUN;
            work_in  = to_chain_ff ? chain_ff : digest_ff;
            rnd_in   = '0;
         end
         ST_RUN: begin
            work_in = round_out;
            rnd_in  = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (to_chain_ff) begin
               chain_in = words_add(chain_ff, work_ff);
               if (fin_pend_ff) begin
                  fin_pend_in = 1'b0;
                  state_in    = ST_FIN_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               digest_in = words_add(digest_ff, work_ff);
               if (second_ff) begin
                  // Padding spilled over: one more block of zeros and length.
                  second_in   = 1'b0;
                  zero_blk_in = 1'b1;
                  len_en_in   = 1'b1;
                  state_in    = ST_LOAD;
               end else begin
                  idx_in   = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff    <= CHAIN_INIT;
         count_ff    <= '0;
         rnd_ff      <= '0;
         fin_pend_ff <= 1'b0;
         second_ff   <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         chain_ff    <= chain_in;
         count_ff    <= count_in;
         rnd_ff      <= rnd_in;
         fin_pend_ff <= fin_pend_in;
         second_ff   <= second_in;
         idx_ff      <= idx_in;
      end
      digest_ff   <= digest_in;
      work_ff     <= work_in;
      fill_ff     <= fill_in;
      to_chain_ff <= to_chain_in;
      zero_blk_ff <= zero_blk_in;
      len_en_ff   <= len_en_in;
   end

   // Handshake and result beat.
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == 2'd3);

   always_comb begin
      unique case (idx_ff)
         2'd0: rsp_digest_word = digest_ff.a;
         2'd1: rsp_digest_word = digest_ff.b;
         2'd2: rsp_digest_word = digest_ff.c;
         2'd3: rsp_digest_word = digest_ff.d;
      endcase
   end

endmodule

[design/md5bsh_checker.sv]
`include "md5_byte_stream_hasher_unit_defines.svh"

module md5bsh_checker
   import md5bsh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word
);

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // A stalled result beat holds its payload.
   `MD5BSH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index), "result beat changed while stalled")

   // The last flag marks exactly the fourth digest word.
   `MD5BSH_ASSERT_SAME(a_last_flag, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 2'd3), "last flag does not match word index")

   // Digest words follow one another without a gap.
   `MD5BSH_ASSERT_NEXT(a_word_seq, clock, reset, rsp_fire && !rsp_last_word, rsp_valid && (rsp_word_index == 2'($past(rsp_word_index) + 2'd1)), "digest word sequence broken")

   // No request is taken while a digest is being delivered.
   `MD5BSH_ASSERT_SAME(a_busy_out, clock, reset, rsp_valid, !req_ready, "request ready during digest output")

   // A digest request keeps the unit busy in the next cycle.
   `MD5BSH_ASSERT_NEXT(a_digest_busy, clock, reset, req_fire && (req_action == ACT_DIGEST || req_action == ACT_ABSORB_DIGEST), !req_ready, "ready right after a digest request")

endmodule

bind md5_byte_stream_hasher_unit md5bsh_checker u_md5bsh_checker (.*);

[test/md5_digest_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the hasher, predicts every digest beat from the
// request beats it has seen, and compares each response beat as it leaves.
module md5_digest_checker
   import md5bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [1:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          mismatch_count,
   output int          words_pending,
   output int          words_checked
);

   // Chaining words packed with word 0 in the low 32 bits.
   localparam logic [127:0] MD5_IV =
      {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

   localparam logic [0:63][31:0] SINE_ADD = {
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

   localparam logic [0:15][4:0] SHIFT_BY = {
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last_flag;
   } digest_beat_type;

   digest_beat_type digest_words_due[$];
   digest_beat_type oldest_due;

   // Running hash state: chaining words, 64 buffered bytes (byte i at bits
   // 8i+7:8i) and the message length in bits.
   logic [127:0] chain_state;
   logic [511:0] block_bytes;
   logic [63:0]  message_bits;

   // One 64-round compression of a block, added into the chaining words.
   function automatic logic [127:0] md5_compress(input logic [127:0] chain_in,
                                                 input logic [511:0] blk);
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t, rot;
      int          g, stage, i, s;
      for (i = 0; i < 16; i++) m[i] = blk[32*i +: 32];
      a = chain_in[31:0];
      b = chain_in[63:32];
      c = chain_in[95:64];
      d = chain_in[127:96];
      for (i = 0; i < 64; i++) begin
         stage = i / 16;
         case (stage)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = a + f + m[g] + SINE_ADD[i];
         s = SHIFT_BY[stage * 4 + i % 4];
         rot = (t << s) | (t >> (32 - s));
         a = d;
         d = c;
         c = b;
         b = b + rot;
      end
      return {chain_in[127:96] + d, chain_in[95:64] + c,
              chain_in[63:32] + b, chain_in[31:0] + a};
   endfunction

   // Pads a copy of the running state and returns the digest words; the
   // running state itself is left untouched.
   function automatic logic [127:0] padded_digest(input logic [127:0] chain_in,
                                                  input logic [511:0] blk,
                                                  input logic [63:0] bits);
      logic [511:0] work;
      logic [127:0] h;
      int           fill, i;
      fill = int'(bits[8:3]);
      work = blk;
      h = chain_in;
      work[8*fill +: 8] = 8'h80;
      for (i = fill + 1; i < 64; i++) work[8*i +: 8] = 8'h00;
      // Not enough room for the length: it goes into a second block.
      if (fill >= 56) begin
         h = md5_compress(h, work);
         work = '0;
      end
      work[448 +: 64] = bits;
      return md5_compress(h, work);
   endfunction

   // Applies one request beat to the running state and queues its digest.
   task automatic apply_request(input logic [1:0] action, input logic [7:0] data);
      logic [127:0] h;
      int           fill, k;
      if (action == ACT_RESTART) begin
         chain_state = MD5_IV;
         message_bits = '0;
      end else begin
         if (action == ACT_ABSORB || action == ACT_ABSORB_DIGEST) begin
            fill = int'(message_bits[8:3]);
            block_bytes[8*fill +: 8] = data;
            message_bits = message_bits + 64'd8;
            if (fill == 63) chain_state = md5_compress(chain_state, block_bytes);
         end
         if (action != ACT_ABSORB) begin
            h = padded_digest(chain_state, block_bytes, message_bits);
            for (k = 0; k < 4; k++)
               digest_words_due.push_back('{word: h[32*k +: 32], index: 2'(k),
                                            last_flag: (k == 3)});
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      words_pending = 0;
      words_checked = 0;
   end

   // Response beats are compared first; a request in the same cycle cannot
   // have produced them.
   always @(posedge clock) begin
      if (reset) begin
         chain_state = MD5_IV;
         message_bits = '0;
         block_bytes = '0;
         digest_words_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_words_due.size() == 0) begin
               $display("%0t: unexpected digest beat word=%08h index=%0d last=%0b",
                        $realtime, rsp_digest_word, rsp_word_index, rsp_last_word);
               mismatch_count++;
            end else begin
               oldest_due = digest_words_due.pop_front();
               words_checked++;
               if (rsp_digest_word !== oldest_due.word ||
                   rsp_word_index !== oldest_due.index ||
                   rsp_last_word !== oldest_due.last_flag) begin
                  $display("%0t: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                           $realtime, oldest_due.word, oldest_due.index,
                           oldest_due.last_flag, rsp_digest_word, rsp_word_index,
                           rsp_last_word);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) apply_request(req_action, req_data_byte);
      end
      words_pending = digest_words_due.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import md5bsh_pkg::*;

   localparam int RANDOM_PHASE_BEATS = 30;
   localparam int LONG_STALL = 400;
   localparam int DRAIN_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_ABSORB;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   int mismatch_count;
   int words_pending;
   int words_checked;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int beats_sent = 0;
   int restarts_sent = 0;
   int stalls_asked = 0;
   int stalls_served = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   md5_byte_stream_hasher_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   md5_digest_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending),
      .words_checked   (words_checked)
   );

   // Receiver: random back-pressure, or a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (stalls_served != stalls_asked) begin
         stalls_served = stalls_served + 1;
         stall_left = LONG_STALL - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $realtime, idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request beat after a random gap and waits until it is taken.
   task automatic send_beat(input logic [1:0] action, input logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_data_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (action == ACT_RESTART) restarts_sent++;
   endtask

   // One message with random content and length, mostly from a fresh start,
   // sometimes continuing the previous one; a few beats are plain noise.
   task automatic hash_random_message();
      int  len, pick, k;
      bit  closed;
      pick = $urandom_range(99);
      if (pick < 10) begin
         send_beat(2'($urandom_range(ACT_RESTART)), 8'($urandom_range(255)));
      end else begin
         if ($urandom_range(3) != 0) send_beat(ACT_RESTART, 8'($urandom_range(255)));
         pick = $urandom_range(9);
         // Lengths around 55..64 reach the padding spill and a full block.
         if (pick < 5) len = $urandom_range(8);
         else if (pick < 8) len = $urandom_range(66, 52);
         else len = $urandom_range(40, 9);
         closed = 1'b0;
         for (k = 0; k < len; k++) begin
            if ($urandom_range(15) == 0) send_beat(ACT_DIGEST, 8'($urandom_range(255)));
            if (k == len - 1 && $urandom_range(1) == 1) begin
               send_beat(ACT_ABSORB_DIGEST, 8'($urandom_range(255)));
               closed = 1'b1;
            end else begin
               send_beat(ACT_ABSORB, 8'($urandom_range(255)));
            end
         end
         if (!closed) send_beat(ACT_DIGEST, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      int phase, k, phase_start;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      rsp_idle_pct = 60;

      // Directed: empty message, "abc", digest twice, continuing after a
      // digest, extreme byte values, and restarts that ignore their byte.
      send_beat(ACT_DIGEST, 8'h5a);
      send_beat(ACT_ABSORB, 8'h61);
      send_beat(ACT_ABSORB, 8'h62);
      send_beat(ACT_ABSORB_DIGEST, 8'h63);
      send_beat(ACT_DIGEST, 8'h00);
      send_beat(ACT_ABSORB, 8'h00);
      send_beat(ACT_ABSORB_DIGEST, 8'hff);
      send_beat(ACT_RESTART, 8'hff);
      send_beat(ACT_DIGEST, 8'hff);
      send_beat(ACT_RESTART, 8'h00);
      send_beat(ACT_RESTART, 8'haa);
      send_beat(ACT_ABSORB_DIGEST, 8'h80);
      send_beat(ACT_ABSORB, 8'h7f);
      send_beat(ACT_DIGEST, 8'h55);

      // Random messages in three idling phases.
      for (phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 60;
            rsp_idle_pct = 38;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
            // Hold the receiver off while digests keep arriving, so the
            // unit backs up and stalls its request side.
            stalls_asked++;
            for (k = 0; k < 6; k++)
               send_beat(k[0] ? ACT_DIGEST : ACT_ABSORB_DIGEST, 8'($urandom_range(255)));
            @(negedge clock);
            req_valid <= 1'b0;
            wait (words_pending == 0);
         end
         phase_start = beats_sent;
         while (beats_sent - phase_start < RANDOM_PHASE_BEATS) hash_random_message();
         // After the first phase the sender pauses until every digest so far has come back.
         if (phase == 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            wait (words_pending == 0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (words_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats (%0d restarts) under three idling mixes.",
               beats_sent, restarts_sent);
      $display("Checked %0d digest words, including a long response hold-off.",
               words_checked);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[md5_byte_stream_hasher_unit.f]
+incdir+design
design/md5bsh_pkg.sv
design/md5bsh_round.sv
design/md5_byte_stream_hasher_unit.sv
design/md5bsh_checker.sv
test/md5_digest_checker.sv
test/testbench.sv
